// ----- src/rgst_pkg.sv -----
// ----------------------------------------------------------------------------
// Range GCD segment tree package
// Shared widths, types and codes for the range GCD segment tree.
// ----------------------------------------------------------------------------
package rgst_pkg;

    localparam int LEAVES      = 1024;
    localparam int IDX_W       = $clog2(LEAVES);
    localparam int NODE_W      = IDX_W + 1;
    localparam int DEPTH       = 2 * LEAVES;
    localparam int VAL_W       = 63;
    localparam int END_W       = 11;

    typedef enum logic
    {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } opcode_t;

    typedef struct packed
    {
        logic              start;
        logic [VAL_W-1:0]  a;
        logic [VAL_W-1:0]  b;
    } gcd_req_t;

    typedef struct packed
    {
        logic              done;
        logic [VAL_W-1:0]  result;
    } gcd_rsp_t;

    typedef enum logic [3:0]
    {
        ST_IDLE,
        ST_WR_LEAF,
        ST_UP_RD,
        ST_UP_WAIT,
        ST_UP_GCD,
        ST_UP_WR,
        ST_Q_STEP,
        ST_Q_WAIT,
        ST_Q_GCD,
        ST_OUT
    } state_t;

    typedef enum logic [1:0]
    {
        GS_IDLE,
        GS_RUN
    } gstate_t;

endpackage

// ----- src/rgst_if.sv -----
// ----------------------------------------------------------------------------
// Range GCD segment tree channels
// Valid/ready interfaces for the input and result words.
// ----------------------------------------------------------------------------
interface rgst_in_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [rgst_pkg::IDX_W-1:0]    leaf_index;
    logic [rgst_pkg::VAL_W-1:0]    leaf_value;
    logic [rgst_pkg::IDX_W-1:0]    range_start;
    logic [rgst_pkg::END_W-1:0]    range_end;

    modport source (output valid, opcode, leaf_index, leaf_value, range_start, range_end,
                    input ready);
    modport sink (input valid, opcode, leaf_index, leaf_value, range_start, range_end,
                  output ready);
endinterface

interface rgst_out_if;
    logic                          valid;
    logic                          ready;
    logic [rgst_pkg::VAL_W-1:0]    gcd_result;

    modport source (output valid, gcd_result, input ready);
    modport sink (input valid, gcd_result, output ready);
endinterface

// ----- src/range_gcd_segment_tree.sv -----
// ----------------------------------------------------------------------------
// Range GCD segment tree
// Segment tree over 1024 leaves in one RAM; point writes and range GCD queries.
// ----------------------------------------------------------------------------
// Items are handled one at a time. The tree lives in a single-port RAM
// whose contents after reset are undefined; a clearing pass that writes
// zero to all 2048 words runs after reset before the first word is
// accepted. The result register holds a finished word until it is taken.
module range_gcd_segment_tree (
    input  logic         clk,
    input  logic         rst_n,
    rgst_in_if.sink      in_ch,
    rgst_out_if.source   out_ch
);

    localparam int NW = rgst_pkg::NODE_W;
    localparam int VW = rgst_pkg::VAL_W;

    rgst_pkg::state_t   state_reg, state_next;
    logic [NW:0]        clr_reg, clr_next;
    logic               clr_done;
    logic [NW-1:0]      p_reg, p_next;
    logic [NW:0]        l_reg, l_next;
    logic [NW:0]        r_reg, r_next;
    logic               side_reg, side_next;
    logic [VW-1:0]      g_reg, g_next;
    logic [VW-1:0]      left_reg, left_next;
    logic [VW-1:0]      res_reg, res_next;
    logic               ovalid_reg, ovalid_next;

    logic               we;
    logic [NW-1:0]      addr;
    logic [VW-1:0]      wdata;
    logic [VW-1:0]      rdata;

    rgst_pkg::gcd_req_t greq;
    rgst_pkg::gcd_rsp_t grsp;

    logic [NW:0]        e_sat;

    rgst_ram #(.WIDTH(VW), .DEPTH(rgst_pkg::DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    rgst_gcd u_gcd (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (greq),
        .rsp   (grsp)
    );

    assign clr_done = clr_reg[NW];
    assign e_sat = (in_ch.range_end > rgst_pkg::END_W'(rgst_pkg::LEAVES))
                   ? (NW+1)'(rgst_pkg::LEAVES) : (NW+1)'(in_ch.range_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= rgst_pkg::ST_IDLE;
            clr_reg    <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg    <= p_next;
        l_reg    <= l_next;
        r_reg    <= r_next;
        side_reg <= side_next;
        g_reg    <= g_next;
        left_reg <= left_next;
        res_reg  <= res_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        p_next      = p_reg;
        l_next      = l_reg;
        r_next      = r_reg;
        side_next   = side_reg;
        g_next      = g_reg;
        left_next   = left_reg;
        res_next    = res_reg;
        ovalid_next = ovalid_reg;
        we          = 1'b0;
        addr        = p_reg;
        wdata       = g_reg;
        greq.start  = 1'b0;
        greq.a      = g_reg;
        greq.b      = rdata;
        in_ch.ready = 1'b0;

        if (ovalid_reg && out_ch.ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            rgst_pkg::ST_IDLE:
            begin
                if (!clr_done)
                begin
                    we       = 1'b1;
                    addr     = clr_reg[NW-1:0];
                    wdata    = '0;
                    clr_next = clr_reg + 1'b1;
                end
                else if (!ovalid_reg)
                begin
                    in_ch.ready = 1'b1;
                    if (in_ch.valid)
                    begin
                        if (in_ch.opcode == rgst_pkg::OP_WRITE)
                        begin
                            p_next     = {1'b1, in_ch.leaf_index};
                            g_next     = in_ch.leaf_value;
                            state_next = rgst_pkg::ST_WR_LEAF;
                        end
                        else
                        begin
                            g_next     = '0;
                            l_next     = {1'b0, 1'b1, in_ch.range_start};
                            r_next     = e_sat + (NW+1)'(rgst_pkg::LEAVES);
                            state_next = ((NW+1)'(in_ch.range_start) < e_sat)
                                         ? rgst_pkg::ST_Q_STEP : rgst_pkg::ST_OUT;
                        end
                    end
                end
            end
            rgst_pkg::ST_WR_LEAF:
            begin
                we         = 1'b1;
                p_next     = p_reg >> 1;
                state_next = rgst_pkg::ST_UP_RD;
            end
            rgst_pkg::ST_UP_RD:
            begin
                addr       = {p_reg[NW-2:0], 1'b0};
                state_next = rgst_pkg::ST_UP_WAIT;
                side_next  = 1'b0;
            end
            rgst_pkg::ST_UP_WAIT:
            begin
                if (side_reg == 1'b0)
                begin
                    left_next  = rdata;
                    side_next  = 1'b1;
                    addr       = {p_reg[NW-2:0], 1'b1};
                end
                else
                begin
                    greq.start = 1'b1;
                    greq.a     = left_reg;
                    greq.b     = rdata;
                    side_next  = 1'b0;
                    state_next = rgst_pkg::ST_UP_GCD;
                end
            end
            rgst_pkg::ST_UP_GCD:
            begin
                if (grsp.done)
                begin
                    g_next     = grsp.result;
                    state_next = rgst_pkg::ST_UP_WR;
                end
            end
            rgst_pkg::ST_UP_WR:
            begin
                we     = 1'b1;
                p_next = p_reg >> 1;
                if (p_reg == NW'(1))
                begin
                    state_next = rgst_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = rgst_pkg::ST_UP_RD;
                end
            end
            rgst_pkg::ST_Q_STEP:
            begin
                if (l_reg >= r_reg)
                begin
                    state_next = rgst_pkg::ST_OUT;
                end
                else if (l_reg[0])
                begin
                    addr       = l_reg[NW-1:0];
                    l_next     = l_reg + 1'b1;
                    state_next = rgst_pkg::ST_Q_WAIT;
                end
                else if (r_reg[0])
                begin
                    addr       = NW'(r_reg - 1'b1);
                    r_next     = r_reg - 1'b1;
                    state_next = rgst_pkg::ST_Q_WAIT;
                end
                else
                begin
                    l_next = l_reg >> 1;
                    r_next = r_reg >> 1;
                end
            end
            rgst_pkg::ST_Q_WAIT:
            begin
                greq.start = 1'b1;
                state_next = rgst_pkg::ST_Q_GCD;
            end
            rgst_pkg::ST_Q_GCD:
            begin
                if (grsp.done)
                begin
                    g_next     = grsp.result;
                    state_next = rgst_pkg::ST_Q_STEP;
                end
            end
            rgst_pkg::ST_OUT:
            begin
                res_next    = g_reg;
                ovalid_next = 1'b1;
                state_next  = rgst_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = rgst_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_ch.valid      = ovalid_reg;
    assign out_ch.gcd_result = res_reg;

endmodule

// ----- src/rgst_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module rgst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [$clog2(DEPTH)-1:0]  addr,
    input  logic [WIDTH-1:0]          wdata,
    output logic [WIDTH-1:0]          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

// ----- src/rgst_gcd.sv -----
// ----------------------------------------------------------------------------
// Binary GCD unit
// Stein's algorithm, one subtract-and-shift step per cycle.
// ----------------------------------------------------------------------------
module rgst_gcd (
    input  logic                clk,
    input  logic                rst_n,
    input  rgst_pkg::gcd_req_t  req,
    output rgst_pkg::gcd_rsp_t  rsp
);

    rgst_pkg::gstate_t              state_reg, state_next;
    logic [rgst_pkg::VAL_W-1:0]     a_reg, a_next;
    logic [rgst_pkg::VAL_W-1:0]     b_reg, b_next;
    logic [6:0]                     k_reg, k_next;
    logic                           done_reg, done_next;
    logic [rgst_pkg::VAL_W-1:0]     diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rgst_pkg::GS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        k_reg <= k_next;
    end

    always_comb
    begin
        state_next = state_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        k_next     = k_reg;
        done_next  = 1'b0;
        diff       = (a_reg > b_reg) ? (a_reg - b_reg) : (b_reg - a_reg);
        case (state_reg)
            rgst_pkg::GS_IDLE:
            begin
                if (req.start)
                begin
                    a_next     = req.a;
                    b_next     = req.b;
                    k_next     = '0;
                    state_next = rgst_pkg::GS_RUN;
                end
            end
            rgst_pkg::GS_RUN:
            begin
                // The result is the nonzero operand (a | b) << k once one operand reaches zero.
                if (a_reg == '0 || b_reg == '0)
                begin
                    a_next     = (a_reg | b_reg) << k_reg;
                    done_next  = 1'b1;
                    state_next = rgst_pkg::GS_IDLE;
                end
                else if (!a_reg[0] && !b_reg[0])
                begin
                    a_next = a_reg >> 1;
                    b_next = b_reg >> 1;
                    k_next = k_reg + 7'd1;
                end
                else if (!a_reg[0])
                begin
                    a_next = a_reg >> 1;
                end
                else if (!b_reg[0])
                begin
                    b_next = b_reg >> 1;
                end
                else
                begin
                    a_next = (a_reg < b_reg) ? a_reg : b_reg;
                    b_next = diff >> 1;
                end
            end
            default:
            begin
                state_next = rgst_pkg::GS_IDLE;
            end
        endcase
    end

    assign rsp.done   = done_reg;
    assign rsp.result = a_reg;

endmodule

// ----- src/rgst_checker.sv -----
// ----------------------------------------------------------------------------
// Range GCD segment tree checker
// Port-level properties of the input and result channels.
// ----------------------------------------------------------------------------
module rgst_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       in_opcode,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rgst_pkg::VAL_W-1:0] out_result
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_result))
        else $error("result word dropped or changed while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("input accepted while a result waits");

    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_opcode == rgst_pkg::OP_WRITE |=> !out_valid)
        else $error("write produced a result word");

    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready in the cycle after an accept");

endmodule

bind range_gcd_segment_tree rgst_checker u_rgst_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_opcode  (in_ch.opcode),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_result (out_ch.gcd_result)
);

// ----- tb/range_gcd_segment_tree_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range GCD segment tree checker
// Watches both channels, keeps its own copy of the tree, predicts the GCD of
// every query and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module range_gcd_segment_tree_checker (
    input  logic          clk,
    input  logic          rst_n,
    rgst_in_if.sink       in_mon,
    rgst_out_if.sink      out_mon,
    output int            fail_count,
    output int            pending,
    output int            queries_seen
);

    logic [rgst_pkg::VAL_W-1:0] shadow_tree [rgst_pkg::DEPTH];
    logic [rgst_pkg::VAL_W-1:0] expected_gcds [$];

    function automatic logic [rgst_pkg::VAL_W-1:0] gcd_of(logic [rgst_pkg::VAL_W-1:0] a,
                                                          logic [rgst_pkg::VAL_W-1:0] b);
        logic [rgst_pkg::VAL_W-1:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    task automatic store_leaf(int idx, logic [rgst_pkg::VAL_W-1:0] val);
        int p;
        p = idx + rgst_pkg::LEAVES;
        shadow_tree[p] = val;
        p = p >> 1;
        while (p >= 1)
        begin
            shadow_tree[p] = gcd_of(shadow_tree[2*p], shadow_tree[2*p+1]);
            p = p >> 1;
        end
    endtask

    function automatic logic [rgst_pkg::VAL_W-1:0] range_gcd(int s, int e);
        logic [rgst_pkg::VAL_W-1:0] g;
        int l;
        int r;
        g = '0;
        if (e > rgst_pkg::LEAVES)
            e = rgst_pkg::LEAVES;
        if (s < e)
        begin
            l = s + rgst_pkg::LEAVES;
            r = e + rgst_pkg::LEAVES;
            while (l < r)
            begin
                if (l[0])
                begin
                    g = gcd_of(g, shadow_tree[l]);
                    l++;
                end
                if (r[0])
                begin
                    r--;
                    g = gcd_of(g, shadow_tree[r]);
                end
                l = l >> 1;
                r = r >> 1;
            end
        end
        return g;
    endfunction

    assign pending = expected_gcds.size();

    always @(posedge clk or negedge rst_n)
    begin
        logic [rgst_pkg::VAL_W-1:0] want;
        if (!rst_n)
        begin
            for (int i = 0; i < rgst_pkg::DEPTH; i++)
                shadow_tree[i] = '0;
            expected_gcds.delete();
            fail_count <= 0;
            queries_seen <= 0;
        end
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_gcds.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("Unexpected result word %0d", out_mon.gcd_result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_gcds.pop_front();
                    if (want !== out_mon.gcd_result)
                    begin
                        if (fail_count < 10)
                            $display("gcd_result mismatch: expected %0d, got %0d",
                                     want, out_mon.gcd_result);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
            begin
                if (rgst_pkg::opcode_t'(in_mon.opcode) == rgst_pkg::OP_WRITE)
                    store_leaf(int'(in_mon.leaf_index), in_mon.leaf_value);
                else
                begin
                    expected_gcds.push_back(range_gcd(int'(in_mon.range_start),
                                                      int'(in_mon.range_end)));
                    queries_seen <= queries_seen + 1;
                end
            end
        end
    end

endmodule

// ----- tb/range_gcd_segment_tree_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Range GCD segment tree testbench
// Drives directed and random leaf writes and range queries with bursty input
// and a stalling result side; the checker judges every result word.
// ----------------------------------------------------------------------------
module range_gcd_segment_tree_tb;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   queries_seen;
    int   words_sent;

    rgst_in_if  in_ch();
    rgst_out_if out_ch();

    range_gcd_segment_tree dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    range_gcd_segment_tree_checker checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch),
        .out_mon      (out_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .queries_seen (queries_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #300ms;
        $display("Timeout with %0d results outstanding", pending);
        $display("CHECKS FAILED");
        $finish;
    end

    // The result side stalls in runs of its own length and density.
    initial
    begin
        int run_len;
        int mode;
        out_ch.ready = 1'b0;
        forever
        begin
            run_len = $urandom_range(1, 40);
            mode = $urandom_range(0, 3);
            repeat (run_len)
            begin
                @(posedge clk);
                case (mode)
                    0: out_ch.ready <= 1'b1;
                    1: out_ch.ready <= 1'b0;
                    default: out_ch.ready <= ($urandom_range(0, 2) != 0);
                endcase
            end
        end
    end

    function automatic logic [rgst_pkg::VAL_W-1:0] random_value();
        logic [rgst_pkg::VAL_W-1:0] v;
        int base;
        v = rgst_pkg::VAL_W'({$urandom, $urandom});
        case ($urandom_range(0, 5))
            0: v = v;
            1: v = v >> $urandom_range(0, 62);
            2: v = '1;
            default:
            begin
                base = $urandom_range(1, 12);
                v = rgst_pkg::VAL_W'(base * $urandom_range(1, 1000));
                v = v << $urandom_range(0, 40);
            end
        endcase
        return v;
    endfunction

    task automatic send_word(rgst_pkg::opcode_t op, int idx,
                             logic [rgst_pkg::VAL_W-1:0] val, int s, int e);
        in_ch.valid       <= 1'b1;
        in_ch.opcode      <= op;
        in_ch.leaf_index  <= idx[rgst_pkg::IDX_W-1:0];
        in_ch.leaf_value  <= val;
        in_ch.range_start <= s[rgst_pkg::IDX_W-1:0];
        in_ch.range_end   <= e[rgst_pkg::END_W-1:0];
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        words_sent++;
    endtask

    task automatic idle_gap(int cycles);
        if (cycles > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic send_random();
        int s;
        int e;
        int w;
        if ($urandom_range(0, 1) == 0)
        begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 63);
            send_word(rgst_pkg::OP_WRITE, w, random_value(), $urandom, $urandom);
        end
        else
        begin
            s = $urandom_range(0, 1023);
            case ($urandom_range(0, 4))
                0: e = $urandom_range(0, 2047);
                1: e = s + $urandom_range(1, 3);
                2: e = $urandom_range(0, 64);
                default: e = s + $urandom_range(0, 1024 - s);
            endcase
            if ($urandom_range(0, 3) != 0 && s > 64)
                s = $urandom_range(0, 63);
            send_word(rgst_pkg::OP_QUERY, $urandom, random_value(), s, e);
        end
    endtask

    initial
    begin
        int burst;
        rst_n = 1'b0;
        words_sent = 0;
        in_ch.valid = 1'b0;
        in_ch.opcode = rgst_pkg::OP_WRITE;
        in_ch.leaf_index = '0;
        in_ch.leaf_value = '0;
        in_ch.range_start = '0;
        in_ch.range_end = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty tree, extreme values, boundary leaves and ranges.
        send_word(rgst_pkg::OP_QUERY, 0, 0, 0, 1024);
        send_word(rgst_pkg::OP_WRITE, 0, '1, 0, 0);
        send_word(rgst_pkg::OP_WRITE, 1023, 63'd0, 0, 0);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 0, 1024);
        send_word(rgst_pkg::OP_WRITE, 1023, 63'h7FFF_FFFF_FFFF_FFFE, 2047, 1023);
        send_word(rgst_pkg::OP_QUERY, 1023, '1, 0, 2047);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 1023, 1024);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 1023, 2047);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 5, 5);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 9, 3);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 1023, 0);
        send_word(rgst_pkg::OP_WRITE, 512, 63'd12, 0, 0);
        send_word(rgst_pkg::OP_WRITE, 513, 63'd18, 0, 0);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 512, 514);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 511, 513);
        send_word(rgst_pkg::OP_WRITE, 0, 63'd1, 0, 0);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 0, 1);
        send_word(rgst_pkg::OP_WRITE, 0, 63'd0, 0, 0);
        send_word(rgst_pkg::OP_WRITE, 1023, 63'd0, 0, 0);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 0, 1024);
        send_word(rgst_pkg::OP_QUERY, 0, 0, 0, 0);
        idle_gap(1);

        // Pause until every expected result has come back.
        while (pending != 0)
            @(posedge clk);

        while (words_sent < 630)
        begin
            burst = $urandom_range(1, 30);
            repeat (burst)
                send_random();
            idle_gap(($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 50));
        end
        idle_gap(1);

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("Sent %0d words, %0d of them range queries, with bursty input",
                 words_sent, queries_seen);
        $display("and a stalling result side.");
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
